// ===== rtl/core/jfss_pkg.sv =====
// ----------------------------------------------------------------------------
// jfss_pkg
// Shared types and marker constants for the JPEG frame size scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jfss_pkg;

    localparam logic [7:0] MARK_PREFIX   = 8'hFF;
    localparam logic [7:0] MARK_EOI      = 8'hD9;
    localparam logic [7:0] MARK_SOF_BASE = 8'hC0;
    localparam logic [7:0] MARK_SOF_TOP  = 8'hCF;
    localparam logic [7:0] MARK_RST_BASE = 8'hD0;
    localparam logic [7:0] MARK_SOI      = 8'hD8;
    localparam logic [7:0] MARK_TEM      = 8'h01;

    localparam logic [15:0] SEG_LEN_MIN  = 16'd2;
    localparam logic [15:0] SOF_LEN_MIN  = 16'd7;

    localparam logic [2:0] HDR_IDX_LEN_LO = 3'd1;
    localparam logic [2:0] HDR_IDX_PREC   = 3'd2;
    localparam logic [2:0] HDR_IDX_LAST   = 3'd6;

    typedef enum logic [6:0] {
        PH_HUNT   = 7'b0000001,
        PH_MARK   = 7'b0000010,
        PH_LEN_HI = 7'b0000100,
        PH_LEN_LO = 7'b0001000,
        PH_SKIP   = 7'b0010000,
        PH_HDR    = 7'b0100000,
        PH_TAIL   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic        status;
        logic [3:0]  frame_code;
        logic [15:0] width;
        logic [15:0] height;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/jpeg_frame_size_scanner.sv =====
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Streams a JPEG file byte by byte and reports the frame header's size.
// ----------------------------------------------------------------------------
// Slave side: one file byte per beat on s_tdata, s_tlast on the final byte.
// Master side: one beat per file, sent after the final byte; m_tuser is the
// status (0 frame header found, 1 none), m_tdata holds code, width, height.
// Throughput: one byte per cycle while s_tready is high. Each byte's parser update is a
// single pass of marker/length logic into the state registers.
// Latency: the result beat is valid the cycle after the final byte is taken
// when no earlier beat waits ahead of it.
// The master side has an output register with a skid register behind it, so
// s_tready comes from a register and never follows m_tready combinationally.
// A stalled receiver blocks nothing until a second result waits in the skid
// register; s_tready is then low until the pending beat leaves.
// Reset: aresetn low for one clock clears parser state and drops m_tvalid.
// After each final byte the parser returns to its reset state on its own,
// ready for the next file's first byte in the next cycle while s_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_frame_size_scanner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // frame_code[3:0], width[19:4], height[35:20]
    output logic [0:0]       m_tuser    // status[0]
);

    jfss_pkg::result_t result;
    logic              beat_fire;

    assign beat_fire = s_tvalid && s_tready;

    jfss_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_fire (beat_fire),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .result    (result)
    );

    jfss_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/jfss_scan.sv =====
// ----------------------------------------------------------------------------
// jfss_scan
// Marker parser state and per-beat next-state logic; emits one result on the
// final beat of a file and returns to its reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module jfss_scan (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              beat_fire,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output jfss_pkg::result_t      result
);

    jfss_pkg::phase_t phase_reg, phase_next;
    logic [15:0] skip_count_reg, skip_count_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [3:0]  candidate_code_reg, candidate_code_next;
    logic [31:0] header_bytes_reg, header_bytes_next;
    logic        best_valid_reg, best_valid_next;
    logic [3:0]  best_code_reg, best_code_next;
    logic [15:0] best_width_reg, best_width_next;
    logic [15:0] best_height_reg, best_height_next;
    logic        halted_reg, halted_next;

    logic [15:0] seg_len;
    logic [15:0] short_skip;
    logic [15:0] skip_dec;
    logic        take_hdr;

    assign seg_len    = {length_high_reg, data_byte};
    assign short_skip = (seg_len < jfss_pkg::SEG_LEN_MIN) ? 16'd0
                                                           : seg_len - jfss_pkg::SEG_LEN_MIN;
    assign skip_dec   = skip_count_reg - 16'd1;

    always_comb begin
        phase_next          = phase_reg;
        skip_count_next     = skip_count_reg;
        length_high_next    = length_high_reg;
        header_index_next   = header_index_reg;
        candidate_code_next = candidate_code_reg;
        header_bytes_next   = header_bytes_reg;
        best_valid_next     = best_valid_reg;
        best_code_next      = best_code_reg;
        best_width_next     = best_width_reg;
        best_height_next    = best_height_reg;
        halted_next         = halted_reg;
        take_hdr            = 1'b0;

        if (!halted_reg) begin
            unique case (phase_reg)
                jfss_pkg::PH_HUNT: begin
                    if (data_byte == jfss_pkg::MARK_PREFIX) begin
                        phase_next = jfss_pkg::PH_MARK;
                    end
                end
                jfss_pkg::PH_MARK: begin
                    priority if (data_byte == jfss_pkg::MARK_PREFIX) begin
                        phase_next = jfss_pkg::PH_MARK;
                    end else if (data_byte == jfss_pkg::MARK_EOI) begin
                        halted_next = 1'b1;
                    end else if (data_byte <= jfss_pkg::MARK_TEM ||
                                 (data_byte >= jfss_pkg::MARK_RST_BASE &&
                                  data_byte <= jfss_pkg::MARK_SOI)) begin
                        phase_next = jfss_pkg::PH_HUNT;
                    end else if (data_byte >= jfss_pkg::MARK_SOF_BASE &&
                                 data_byte <= jfss_pkg::MARK_SOF_TOP) begin
                        candidate_code_next = data_byte[3:0];
                        header_index_next   = 3'd0;
                        header_bytes_next   = 32'd0;
                        phase_next          = jfss_pkg::PH_HDR;
                    end else begin
                        phase_next = jfss_pkg::PH_LEN_HI;
                    end
                end
                jfss_pkg::PH_LEN_HI: begin
                    length_high_next = data_byte;
                    phase_next       = jfss_pkg::PH_LEN_LO;
                end
                jfss_pkg::PH_LEN_LO: begin
                    skip_count_next = short_skip;
                    phase_next      = (short_skip == 16'd0) ? jfss_pkg::PH_HUNT
                                                            : jfss_pkg::PH_SKIP;
                end
                jfss_pkg::PH_SKIP: begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = jfss_pkg::PH_HUNT;
                    end
                end
                jfss_pkg::PH_HDR: begin
                    priority if (header_index_reg == 3'd0) begin
                        length_high_next  = data_byte;
                        header_index_next = jfss_pkg::HDR_IDX_LEN_LO;
                    end else if (header_index_reg == jfss_pkg::HDR_IDX_LEN_LO) begin
                        if (seg_len < jfss_pkg::SOF_LEN_MIN) begin
                            skip_count_next = short_skip;
                            phase_next      = (short_skip == 16'd0) ? jfss_pkg::PH_HUNT
                                                                    : jfss_pkg::PH_SKIP;
                        end else begin
                            skip_count_next   = seg_len - jfss_pkg::SEG_LEN_MIN;
                            header_index_next = jfss_pkg::HDR_IDX_PREC;
                        end
                    end else begin
                        if (header_index_reg > jfss_pkg::HDR_IDX_PREC) begin
                            header_bytes_next = {header_bytes_reg[23:0], data_byte};
                        end
                        skip_count_next = skip_dec;
                        if (header_index_reg >= jfss_pkg::HDR_IDX_LAST) begin
                            if (skip_dec == 16'd0) begin
                                take_hdr   = 1'b1;
                                phase_next = jfss_pkg::PH_HUNT;
                            end else begin
                                phase_next = jfss_pkg::PH_TAIL;
                            end
                        end else begin
                            header_index_next = header_index_reg + 3'd1;
                        end
                    end
                end
                jfss_pkg::PH_TAIL: begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        take_hdr   = 1'b1;
                        phase_next = jfss_pkg::PH_HUNT;
                    end
                end
                default: begin
                    phase_next = jfss_pkg::PH_HUNT;
                end
            endcase
        end

        // header ending on the final beat counts as cut off
        if (take_hdr && !last_byte &&
            (!best_valid_reg || candidate_code_next < best_code_reg)) begin
            best_valid_next  = 1'b1;
            best_code_next   = candidate_code_next;
            best_height_next = header_bytes_next[31:16];
            best_width_next  = header_bytes_next[15:0];
        end

        if (last_byte) begin
            phase_next          = jfss_pkg::PH_HUNT;
            skip_count_next     = 16'd0;
            length_high_next    = 8'd0;
            header_index_next   = 3'd0;
            candidate_code_next = 4'd0;
            header_bytes_next   = 32'd0;
            best_valid_next     = 1'b0;
            best_code_next      = 4'd0;
            best_width_next     = 16'd0;
            best_height_next    = 16'd0;
            halted_next         = 1'b0;
        end
    end

    always_comb begin
        result.valid      = beat_fire && last_byte;
        result.status     = !best_valid_reg;
        result.frame_code = best_valid_reg ? best_code_reg : 4'd0;
        result.width      = best_valid_reg ? best_width_reg : 16'd0;
        result.height     = best_valid_reg ? best_height_reg : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= jfss_pkg::PH_HUNT;
            skip_count_reg     <= 16'd0;
            length_high_reg    <= 8'd0;
            header_index_reg   <= 3'd0;
            candidate_code_reg <= 4'd0;
            header_bytes_reg   <= 32'd0;
            best_valid_reg     <= 1'b0;
            best_code_reg      <= 4'd0;
            best_width_reg     <= 16'd0;
            best_height_reg    <= 16'd0;
            halted_reg         <= 1'b0;
        end else if (beat_fire) begin
            phase_reg          <= phase_next;
            skip_count_reg     <= skip_count_next;
            length_high_reg    <= length_high_next;
            header_index_reg   <= header_index_next;
            candidate_code_reg <= candidate_code_next;
            header_bytes_reg   <= header_bytes_next;
            best_valid_reg     <= best_valid_next;
            best_code_reg      <= best_code_next;
            best_width_reg     <= best_width_next;
            best_height_reg    <= best_height_next;
            halted_reg         <= halted_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == jfss_pkg::PH_SKIP || phase_reg == jfss_pkg::PH_TAIL)
        |-> skip_count_reg != 16'd0)
        else $error("skip phase with zero count");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_fire && last_byte
        |=> phase_reg == jfss_pkg::PH_HUNT && !best_valid_reg && !halted_reg)
        else $error("state not cleared after final beat");

    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_fire && !last_byte && best_valid_reg
        |=> best_valid_reg && best_code_reg <= $past(best_code_reg))
        else $error("best frame code went up");

    a_halt_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_fire && !last_byte && halted_reg
        |=> halted_reg && $stable(best_code_reg) && $stable(best_width_reg))
        else $error("state changed after end of image");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/jfss_out.sv =====
// ----------------------------------------------------------------------------
// jfss_out
// Result register on the master side with a skid register behind it; the
// input stalls only while both hold a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jfss_out (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  jfss_pkg::result_t      result,
    output logic                   in_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,
    output logic [0:0]             m_tuser
);

    logic        valid_reg;
    logic        status_reg;
    logic [3:0]  code_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        skid_valid_reg;
    logic        skid_status_reg;
    logic [3:0]  skid_code_reg;
    logic [15:0] skid_width_reg;
    logic [15:0] skid_height_reg;
    logic        out_pop;
    logic        out_load;
    logic        skid_load;

    assign in_ready  = !skid_valid_reg;
    assign out_pop   = valid_reg && m_tready;
    assign out_load  = !valid_reg || out_pop;
    assign skid_load = result.valid && !out_load;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {4'd0, height_reg, width_reg, code_reg};
    assign m_tuser   = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                valid_reg <= skid_valid_reg || result.valid;
            end
            if (skid_valid_reg) begin
                if (out_pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (skid_load) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (skid_valid_reg) begin
                status_reg <= skid_status_reg;
                code_reg   <= skid_code_reg;
                width_reg  <= skid_width_reg;
                height_reg <= skid_height_reg;
            end else if (result.valid) begin
                status_reg <= result.status;
                code_reg   <= result.frame_code;
                width_reg  <= result.width;
                height_reg <= result.height;
            end
        end
        if (skid_load) begin
            skid_status_reg <= result.status;
            skid_code_reg   <= result.frame_code;
            skid_width_reg  <= result.width;
            skid_height_reg <= result.height;
        end
    end

endmodule

`default_nettype wire
